@@ rtl/modexp_pkg.sv @@
// shared widths for the modular exponentiation block
package modexp_pkg;

    // operand width of base, exponent and modulus (8 to 32)
    localparam int OPERAND_WIDTH = 32;

    // width of the external fields
    localparam int FIELD_WIDTH = 32;

    // bit counter of the serial multiplier, holds 0..OPERAND_WIDTH
    localparam int COUNT_WIDTH = $clog2(OPERAND_WIDTH + 1);

    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [COUNT_WIDTH-1:0]   count_t;

endpackage

@@ rtl/modular_exponentiation.sv @@
// modular exponentiation top level: control sequencer, modulus register, result register
//
// Computes base ** exponent mod modulus by right-to-left square-and-multiply. The
// modulus is written through its own valid/ready port (always ready, reset value 1)
// and must only be changed while no transaction is in flight. Each accepted operand
// transaction yields exactly one power_result transaction. An exponent of zero gives
// 1 without reduction (even for modulus 1); a zero modulus with a nonzero exponent
// gives 0. All arithmetic goes through one bit-serial modular multiplier that takes
// one multiplier bit per cycle. The base is first reduced by one pass of that unit,
// then every exponent bit up to the highest set bit costs one pass through the
// sequencing state, one squaring, and one multiplication when the bit is set (the
// squaring starts right behind the multiplication). A zero exponent or zero modulus
// skips the multiplier and goes straight to the finish state. A held result adds its
// stall on top only when the next result is ready before the held one is taken. One
// transaction is worked on at a time; a new one is taken as soon as the sequencer is
// idle, even while the previous result still waits in the output register.
module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write channel
    input  logic                   modulus_valid,
    output logic                   modulus_ready,
    input  logic [FIELD_WIDTH-1:0] modulus,
    // operand channel
    input  logic                   operands_valid,
    output logic                   operands_ready,
    input  logic [FIELD_WIDTH-1:0] base,
    input  logic [FIELD_WIDTH-1:0] exponent,
    // result channel
    output logic                   power_result_valid,
    input  logic                   power_result_ready,
    output logic [FIELD_WIDTH-1:0] power_result
);

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,  // waiting for an operand transaction
        ST_REDUCE = 6'b000010,  // base mod n running
        ST_STEP   = 6'b000100,  // decide on the next exponent bit
        ST_MUL    = 6'b001000,  // acc * base mod n running
        ST_SQR    = 6'b010000,  // base * base mod n running
        ST_FINISH = 6'b100000   // hand result to the output register
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [FIELD_WIDTH-1:0] modulus_reg;
    logic [FIELD_WIDTH-1:0] modulus_next;

    operand_t n_op;
    operand_t one_mod_n;

    operand_t acc_reg;
    operand_t acc_next;
    operand_t b_reg;
    operand_t b_next;
    operand_t e_reg;
    operand_t e_next;
    operand_t res_reg;
    operand_t res_next;

    logic [FIELD_WIDTH-1:0] out_reg;
    logic [FIELD_WIDTH-1:0] out_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic     in_fire;
    logic     out_free;
    logic     mm_start;
    operand_t mm_a;
    operand_t mm_b;
    logic     mm_done;
    operand_t mm_product;

    // only the low operand bits of the modulus take part
    assign n_op      = modulus_reg[W-1:0];
    assign one_mod_n = (n_op == operand_t'(1)) ? '0 : operand_t'(1);

    assign modulus_ready  = 1'b1;
    assign operands_ready = (state_reg == ST_IDLE);
    assign in_fire        = operands_valid && operands_ready;
    assign out_free       = !out_valid_reg || power_result_ready;

    always_comb
    begin
        modulus_next = modulus_reg;
        if (modulus_valid)
        begin
            modulus_next = modulus;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        e_next         = e_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mm_start       = 1'b0;
        mm_a           = b_reg;
        mm_b           = b_reg;

        if (out_valid_reg && power_result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    e_next   = exponent[W-1:0];
                    acc_next = one_mod_n;
                    if (exponent[W-1:0] == '0)
                    begin
                        // zero exponent gives 1, not reduced
                        res_next   = operand_t'(1);
                        state_next = ST_FINISH;
                    end
                    else if (n_op == '0)
                    begin
                        res_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // base mod n as base * (1 mod n)
                        mm_start   = 1'b1;
                        mm_a       = base[W-1:0];
                        mm_b       = one_mod_n;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mm_done)
                begin
                    b_next     = mm_product;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (e_reg == '0)
                begin
                    res_next   = acc_reg;
                    state_next = ST_FINISH;
                end
                else if (e_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_a       = acc_reg;
                    mm_b       = b_reg;
                    state_next = ST_MUL;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_product;
                    mm_start   = 1'b1;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mm_done)
                begin
                    b_next     = mm_product;
                    e_next     = {1'b0, e_reg[W-1:1]};
                    state_next = ST_STEP;
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    out_next       = FIELD_WIDTH'(res_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    modexp_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .mul_a   (mm_a),
        .mul_b   (mm_b),
        .modulus (n_op),
        .done    (mm_done),
        .product (mm_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= FIELD_WIDTH'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
        e_reg   <= e_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign power_result_valid = out_valid_reg;
    assign power_result       = out_reg;

endmodule

@@ rtl/modexp_modmul.sv @@
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module modexp_modmul
    import modexp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  operand_t mul_a,
    input  operand_t mul_b,
    input  operand_t modulus,
    output logic     done,
    output operand_t product
);

    localparam int W = OPERAND_WIDTH;

    typedef logic [W+1:0] wide_t;

    operand_t a_sh_reg;
    operand_t a_sh_next;
    operand_t b_reg;
    operand_t b_next;
    operand_t r_reg;
    operand_t r_next;
    count_t   cnt_reg;
    count_t   cnt_next;
    logic     busy_reg;
    logic     busy_next;
    logic     done_reg;
    logic     done_next;

    wide_t sum;
    wide_t n_one;
    wide_t n_two;

    // r = 2r + bit*b, then bring back below n (at most two subtractions)
    always_comb
    begin
        n_one = wide_t'(modulus);
        n_two = wide_t'({modulus, 1'b0});
        sum   = wide_t'({r_reg, 1'b0}) + (a_sh_reg[W-1] ? wide_t'(b_reg) : '0);
    end

    always_comb
    begin
        a_sh_next = a_sh_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_sh_next = mul_a;
            b_next    = mul_b;
            r_next    = '0;
            cnt_next  = count_t'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            a_sh_next = {a_sh_reg[W-2:0], 1'b0};
            if (sum >= n_two)
            begin
                r_next = operand_t'(sum - n_two);
            end
            else if (sum >= n_one)
            begin
                r_next = operand_t'(sum - n_one);
            end
            else
            begin
                r_next = operand_t'(sum);
            end
            cnt_next = cnt_reg - count_t'(1);
            if (cnt_reg == count_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sh_reg <= a_sh_next;
        b_reg    <= b_next;
        r_reg    <= r_next;
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the modular exponentiation block
module testbench;
    import modexp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // operand width as the block uses it, clamped to 8..32
    localparam int OP_BITS = (OPERAND_WIDTH < 8) ? 8 :
                             ((OPERAND_WIDTH > 32) ? 32 : OPERAND_WIDTH);
    localparam logic [63:0] OP_MASK = (64'd1 << OP_BITS) - 64'd1;

    // generous cycle budget
    localparam int CYCLE_LIMIT = 8_000_000;
    // quiet time at the end, about one worst-case computation
    localparam int SETTLE_CYCLES = 2400;

    typedef struct {
        logic [FIELD_WIDTH-1:0] base;
        logic [FIELD_WIDTH-1:0] exponent;
    } operand_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   modulus_valid = 1'b0;
    logic                   modulus_ready;
    logic [FIELD_WIDTH-1:0] modulus = '0;

    logic                   operands_valid = 1'b0;
    logic                   operands_ready;
    logic [FIELD_WIDTH-1:0] base = '0;
    logic [FIELD_WIDTH-1:0] exponent = '0;

    logic                   power_result_valid;
    logic                   power_result_ready = 1'b0;
    logic [FIELD_WIDTH-1:0] power_result;

    // operand pairs waiting to be driven, powers waiting to come back
    operand_pair_t          pending_operands[$];
    logic [FIELD_WIDTH-1:0] expected_powers[$];

    // modulus the block currently holds, reset value 1
    logic [FIELD_WIDTH-1:0] modulus_setting = 1;

    int  queued_count = 0;
    int  accepted_count = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  operand_gap = 0;
    int  result_stall = 0;
    // no idling on either side while set
    bit  steady = 1'b1;

    modular_exponentiation dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .modulus_valid      (modulus_valid),
        .modulus_ready      (modulus_ready),
        .modulus            (modulus),
        .operands_valid     (operands_valid),
        .operands_ready     (operands_ready),
        .base               (base),
        .exponent           (exponent),
        .power_result_valid (power_result_valid),
        .power_result_ready (power_result_ready),
        .power_result       (power_result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // right-to-left square-and-multiply at double width
    function automatic logic [FIELD_WIDTH-1:0] predict_power(
        input logic [FIELD_WIDTH-1:0] b_in,
        input logic [FIELD_WIDTH-1:0] e_in,
        input logic [FIELD_WIDTH-1:0] n_in
    );
        logic [63:0] b;
        logic [63:0] e;
        logic [63:0] n;
        logic [63:0] acc;
        b = {32'd0, b_in} & OP_MASK;
        e = {32'd0, e_in} & OP_MASK;
        n = {32'd0, n_in} & OP_MASK;
        acc = 64'd1;
        // zero exponent gives 1 unreduced, even for modulus 1
        if (e == 0)
            return 1;
        // zero modulus has no reduction defined
        if (n == 0)
            return 0;
        // base at or above the modulus is reduced by the first product
        for (int i = 0; i < 32; i++)
        begin
            if (e == 0)
                break;
            if (e[0])
                acc = (acc * b) % n;
            b = (b * b) % n;
            e = e >> 1;
        end
        return acc[FIELD_WIDTH-1:0];
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle(input int long_lo, input int long_hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 4);
        else if (r < 97)
            return $urandom_range(5, 30);
        else
            return $urandom_range(long_lo, long_hi);
    endfunction

    task automatic add_operands(input logic [FIELD_WIDTH-1:0] b,
                                input logic [FIELD_WIDTH-1:0] e);
        operand_pair_t pair;
        pair.base = b;
        pair.exponent = e;
        pending_operands.push_back(pair);
        queued_count++;
    endtask

    // all queued pairs accepted and every power returned
    task automatic wait_idle();
        while (accepted_count != queued_count || expected_powers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // single transaction on the configuration channel, block idle
    task automatic write_modulus(input logic [FIELD_WIDTH-1:0] value);
        @(posedge clk);
        modulus_valid <= 1'b1;
        modulus <= value;
        do
            @(posedge clk);
        while (!modulus_ready);
        modulus_valid <= 1'b0;
        modulus_setting = value;
    endtask

    // operand driver: holds valid and payload until accepted, then idles at random
    always @(posedge clk)
    begin : operand_driver
        bit send;
        operand_pair_t pair;
        if (rst_n)
        begin
            send = operands_valid;
            if (operands_valid && operands_ready)
            begin
                // prediction uses the modulus in force when the transaction is taken
                expected_powers.push_back(predict_power(base, exponent, modulus_setting));
                accepted_count++;
                send = 1'b0;
                operand_gap = steady ? 0 : pick_idle(50, 300);
            end
            if (!send)
            begin
                if (operand_gap > 0)
                    operand_gap--;
                else if (pending_operands.size() > 0)
                begin
                    pair = pending_operands.pop_front();
                    base <= pair.base;
                    exponent <= pair.exponent;
                    send = 1'b1;
                end
            end
            operands_valid <= send;
        end
    end

    // result monitor: checks each returned power, stalls ready at random;
    // long stalls let the next computation finish behind a held result
    always @(posedge clk)
    begin : result_monitor
        logic [FIELD_WIDTH-1:0] want;
        if (rst_n)
        begin
            if (power_result_valid && power_result_ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("power_result: unexpected transaction, actual %08h", power_result);
                    mismatches++;
                end
                else
                begin
                    want = expected_powers.pop_front();
                    if (power_result !== want)
                    begin
                        $error("power_result mismatch: expected %08h, actual %08h",
                               want, power_result);
                        mismatches++;
                    end
                end
                result_stall = steady ? 0 : pick_idle(500, 2500);
            end
            if (result_stall > 0)
            begin
                result_stall--;
                power_result_ready <= 1'b0;
            end
            else
                power_result_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [FIELD_WIDTH-1:0] phase_moduli[10];
        logic [FIELD_WIDTH-1:0] b;
        logic [FIELD_WIDTH-1:0] e;
        int r;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset modulus of 1: zero exponent still gives 1, anything else 0
        steady = 1'b1;
        add_operands(32'hFFFF_FFFF, 32'd0);
        add_operands(32'd7, 32'd1);
        add_operands(32'd0, 32'hFFFF_FFFF);
        wait_idle();

        // largest modulus: field extremes, base equal to the modulus, long exponents
        write_modulus(32'hFFFF_FFFF);
        steady = 1'b0;
        add_operands(32'd0, 32'd0);
        add_operands(32'hFFFF_FFFF, 32'd0);
        add_operands(32'd0, 32'd1);
        add_operands(32'd0, 32'hFFFF_FFFF);
        add_operands(32'd1, 32'hFFFF_FFFF);
        add_operands(32'hFFFF_FFFF, 32'd1);
        add_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_operands(32'hFFFF_FFFE, 32'd2);
        add_operands(32'd2, 32'd31);
        add_operands(32'd2, 32'd32);
        add_operands(32'd3, 32'h8000_0000);
        add_operands(32'h1234_5678, 32'h0001_0001);
        wait_idle();

        // zero modulus: zero exponent gives 1, otherwise 0
        write_modulus(32'd0);
        add_operands(32'd5, 32'd0);
        add_operands(32'd5, 32'd1);
        add_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        // one modulus per random phase, extremes among them
        phase_moduli[0] = $urandom | 32'h8000_0000;
        phase_moduli[1] = 32'd1;
        phase_moduli[2] = $urandom_range(2, 255);
        phase_moduli[3] = 32'h8000_0000;
        phase_moduli[4] = $urandom;
        phase_moduli[5] = 32'd0;
        phase_moduli[6] = $urandom_range(256, 65535);
        phase_moduli[7] = 32'hFFFF_FFFF;
        phase_moduli[8] = 32'd2;
        phase_moduli[9] = $urandom | 32'd1;

        for (int phase = 0; phase < 10; phase++)
        begin
            write_modulus(phase_moduli[phase]);
            steady = ($urandom_range(0, 9) < 3);
            for (int k = 0; k < 26; k++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    b = '0;
                else if (r == 1)
                    b = '1;
                else if (r == 2)
                    b = $urandom_range(0, 15);
                else
                    b = $urandom;
                // short exponents keep the run brief, full ones cover every bit
                r = $urandom_range(0, 9);
                if (r < 4)
                    e = $urandom;
                else if (r < 7)
                    e = $urandom_range(0, 255);
                else if (r < 9)
                    e = $urandom >> $urandom_range(0, 31);
                else
                begin
                    r = $urandom_range(0, 2);
                    e = (r == 0) ? '0 : ((r == 1) ? 32'd1 : '1);
                end
                add_operands(b, e);
            end
            wait_idle();
        end

        // catch any stray result
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_powers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
